>>> design/evm_pkg.sv
// ----------------------------------------------------------------------------
// evm_pkg: shared types and constants for the YXZ view matrix block
// Fixed-point formats, CORDIC tables and rounding helpers.
// ----------------------------------------------------------------------------
package evm_pkg;

  localparam int CW    = 34;
  localparam int STEPS = 24;
  localparam int BW    = 18;
  localparam int PW    = 32;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic signed [CW-1:0] ATAN_Z [0:STEPS-1] = '{
    CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
    CW'(42667331),  CW'(21354465),  CW'(10680862),  CW'(5340245),
    CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
    CW'(166886),    CW'(83443),     CW'(41722),     CW'(20861),
    CW'(10430),     CW'(5215),      CW'(2608),      CW'(1304),
    CW'(652),       CW'(326),       CW'(163),       CW'(81)
  };

  typedef struct packed {
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
    logic signed [31:0]   z_yaw;
    logic signed [31:0]   z_pitch;
    logic signed [31:0]   z_roll;
    logic [2:0]           flip;
  } front_item_t;

  function automatic logic signed [BW-1:0] clamp_unit(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + CW'(8192)) >>> 14;
    if (t > CW'(65536)) return BW'(65536);
    if (t < -CW'(65536)) return -BW'(65536);
    return BW'(t);
  endfunction

  function automatic logic signed [BW-1:0] basis_round(input logic signed [55:0] q);
    logic signed [55:0] t;
    t = (q + 56'sh80000000) >>> 32;
    if (t > 56'sd65536) return BW'(65536);
    if (t < -56'sd65536) return -BW'(65536);
    return BW'(t);
  endfunction

  function automatic logic signed [PW-1:0] shift_round(input logic signed [52:0] d);
    logic signed [52:0] t;
    t = (d + 53'sd32768) >>> 16;
    if (t > 53'sd2147483647) return 32'sh7fffffff;
    if (t < -53'sd2147483648) return 32'sh80000000;
    return PW'(t);
  endfunction

endpackage

>>> design/evm_front.sv
// ----------------------------------------------------------------------------
// evm_front: request intake
// Registers a pose and folds each angle into the right half-plane.
// ----------------------------------------------------------------------------
module evm_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [31:0]          pos_x,
  input  logic signed [31:0]          pos_y,
  input  logic signed [31:0]          pos_z,
  input  logic signed [15:0]          pitch_angle,
  input  logic signed [15:0]          yaw_angle,
  input  logic signed [15:0]          roll_angle,
  input  logic                        q_full,
  output logic                        busy,
  output logic                        push,
  output evm_pkg::front_item_t        item
);
  import evm_pkg::*;

  logic valid;
  logic take;

  function automatic logic signed [31:0] fold(input logic [15:0] a);
    logic f;
    f = a[15] ^ a[14];
    return {a[15] ^ f, a[14:0], 16'h0000};
  endfunction

  assign busy = valid && q_full;
  assign push = valid && !q_full;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.pos_x   <= pos_x;
      item.pos_y   <= pos_y;
      item.pos_z   <= pos_z;
      item.z_yaw   <= fold(yaw_angle);
      item.z_pitch <= fold(pitch_angle);
      item.z_roll  <= fold(roll_angle);
      item.flip    <= {yaw_angle[15] ^ yaw_angle[14], pitch_angle[15] ^ pitch_angle[14],
                       roll_angle[15] ^ roll_angle[14]};
    end
  end
endmodule

>>> design/evm_queue.sv
// ----------------------------------------------------------------------------
// evm_queue: two-entry request queue
// Decouples the intake from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module evm_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  evm_pkg::front_item_t wr_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output evm_pkg::front_item_t rd_item
);
  import evm_pkg::*;

  front_item_t mem [0:1];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_pop;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign do_pop    = pop && not_empty;
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end
endmodule

>>> design/evm_cordic.sv
// ----------------------------------------------------------------------------
// evm_cordic: pipelined sine and cosine
// One rotation step per stage, then rounding to Q1.16.
// ----------------------------------------------------------------------------
module evm_cordic (
  input  logic                             clk,
  input  logic signed [31:0]               ang_z,
  input  logic                             flip,
  output logic signed [evm_pkg::BW-1:0]    sin_q,
  output logic signed [evm_pkg::BW-1:0]    cos_q
);
  import evm_pkg::*;

  logic signed [CW-1:0] xs [1:STEPS];
  logic signed [CW-1:0] ys [1:STEPS];
  logic signed [CW-1:0] zs [1:STEPS];
  logic                 fl [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] xi, yi, zi;
    logic                 fi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = CW'(ang_z);
      assign fi = flip;
    end else begin : g_next
      assign xi = xs[i];
      assign yi = ys[i];
      assign zi = zs[i];
      assign fi = fl[i];
    end
    always_ff @(posedge clk) begin
      if (!zi[CW-1]) begin
        xs[i+1] <= xi - (yi >>> i);
        ys[i+1] <= yi + (xi >>> i);
        zs[i+1] <= zi - ATAN_Z[i];
      end else begin
        xs[i+1] <= xi + (yi >>> i);
        ys[i+1] <= yi - (xi >>> i);
        zs[i+1] <= zi + ATAN_Z[i];
      end
      fl[i+1] <= fi;
    end
  end

  always_ff @(posedge clk) begin
    cos_q <= clamp_unit(fl[STEPS] ? -xs[STEPS] : xs[STEPS]);
    sin_q <= clamp_unit(fl[STEPS] ? -ys[STEPS] : ys[STEPS]);
  end
endmodule

>>> design/evm_back.sv
// ----------------------------------------------------------------------------
// evm_back: basis and translation pipeline
// Three CORDIC lanes, product stages for the basis, then dot products.
// ----------------------------------------------------------------------------
module evm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  evm_pkg::front_item_t          in_item,
  output logic                          done,
  output logic signed [evm_pkg::BW-1:0] right_x,
  output logic signed [evm_pkg::BW-1:0] right_y,
  output logic signed [evm_pkg::BW-1:0] right_z,
  output logic signed [evm_pkg::BW-1:0] up_x,
  output logic signed [evm_pkg::BW-1:0] up_y,
  output logic signed [evm_pkg::BW-1:0] up_z,
  output logic signed [evm_pkg::BW-1:0] fwd_x,
  output logic signed [evm_pkg::BW-1:0] fwd_y,
  output logic signed [evm_pkg::BW-1:0] fwd_z,
  output logic signed [evm_pkg::PW-1:0] shift_u,
  output logic signed [evm_pkg::PW-1:0] shift_v,
  output logic signed [evm_pkg::PW-1:0] shift_w
);
  import evm_pkg::*;

  localparam int CLAT = STEPS + 1;
  localparam int VLAT = CLAT + 6;

  logic signed [BW-1:0] s1, c1, s2, c2, s3, c3;
  logic                 vl [1:VLAT];
  logic signed [PW-1:0] px [1:CLAT+3];
  logic signed [PW-1:0] py [1:CLAT+3];
  logic signed [PW-1:0] pz [1:CLAT+3];

  evm_cordic u_yaw   (.clk(clk), .ang_z(in_item.z_yaw),   .flip(in_item.flip[2]),
                      .sin_q(s1), .cos_q(c1));
  evm_cordic u_pitch (.clk(clk), .ang_z(in_item.z_pitch), .flip(in_item.flip[1]),
                      .sin_q(s2), .cos_q(c2));
  evm_cordic u_roll  (.clk(clk), .ang_z(in_item.z_roll),  .flip(in_item.flip[0]),
                      .sin_q(s3), .cos_q(c3));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= VLAT; k++) vl[k] <= 1'b0;
    end else begin
      vl[1] <= in_valid;
      for (int k = 2; k <= VLAT; k++) vl[k] <= vl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    px[1] <= in_item.pos_x;
    py[1] <= in_item.pos_y;
    pz[1] <= in_item.pos_z;
    for (int k = 2; k <= CLAT + 3; k++) begin
      px[k] <= px[k-1];
      py[k] <= py[k-1];
      pz[k] <= pz[k-1];
    end
  end

  logic signed [35:0] c1c3, s1s2, c2s3, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2, c1s2;
  logic signed [BW-1:0] s2a, s3a;

  always_ff @(posedge clk) begin
    c1c3 <= c1 * c3;
    s1s2 <= s1 * s2;
    c2s3 <= c2 * s3;
    c3s1 <= c3 * s1;
    c1s3 <= c1 * s3;
    c2c3 <= c2 * c3;
    s1s3 <= s1 * s3;
    c2s1 <= c2 * s1;
    c1c2 <= c1 * c2;
    c1s2 <= c1 * s2;
    s2a  <= s2;
    s3a  <= s3;
  end

  logic signed [53:0] t0, t2, t3, t5;
  logic signed [35:0] k_c1c3, k_c2s3, k_c3s1, k_c1s3, k_c2c3, k_s1s3, k_c2s1, k_c1c2;
  logic signed [BW-1:0] s2b;

  always_ff @(posedge clk) begin
    t0     <= s1s2 * s3a;
    t2     <= c1s2 * s3a;
    t3     <= c3s1 * s2a;
    t5     <= c1c3 * s2a;
    k_c1c3 <= c1c3;
    k_c2s3 <= c2s3;
    k_c3s1 <= c3s1;
    k_c1s3 <= c1s3;
    k_c2c3 <= c2c3;
    k_s1s3 <= s1s3;
    k_c2s1 <= c2s1;
    k_c1c2 <= c1c2;
    s2b    <= s2a;
  end

  logic signed [BW-1:0] b [0:8];

  always_ff @(posedge clk) begin
    b[0] <= basis_round((56'(k_c1c3) <<< 16) + 56'(t0));
    b[1] <= basis_round(56'(k_c2s3) <<< 16);
    b[2] <= basis_round(56'(t2) - (56'(k_c3s1) <<< 16));
    b[3] <= basis_round(56'(t3) - (56'(k_c1s3) <<< 16));
    b[4] <= basis_round(56'(k_c2c3) <<< 16);
    b[5] <= basis_round(56'(t5) + (56'(k_s1s3) <<< 16));
    b[6] <= basis_round(56'(k_c2s1) <<< 16);
    b[7] <= basis_round(-(56'(s2b) <<< 32));
    b[8] <= basis_round(56'(k_c1c2) <<< 16);
  end

  logic signed [49:0]   m [0:8];
  logic signed [BW-1:0] bb [0:8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      m[3*k]   <= b[3*k]   * px[CLAT+3];
      m[3*k+1] <= b[3*k+1] * py[CLAT+3];
      m[3*k+2] <= b[3*k+2] * pz[CLAT+3];
    end
    for (int k = 0; k < 9; k++) bb[k] <= b[k];
  end

  logic signed [52:0]   d [0:2];
  logic signed [BW-1:0] bc [0:8];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      d[k] <= -(53'(m[3*k]) + 53'(m[3*k+1]) + 53'(m[3*k+2]));
    end
    for (int k = 0; k < 9; k++) bc[k] <= bb[k];
  end

  always_ff @(posedge clk) begin
    right_x <= bc[0];
    right_y <= bc[1];
    right_z <= bc[2];
    up_x    <= bc[3];
    up_y    <= bc[4];
    up_z    <= bc[5];
    fwd_x   <= bc[6];
    fwd_y   <= bc[7];
    fwd_z   <= bc[8];
    shift_u <= shift_round(d[0]);
    shift_v <= shift_round(d[1]);
    shift_w <= shift_round(d[2]);
  end

  assign done = vl[VLAT];
endmodule

>>> design/euler_yxz_view_matrix.sv
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix: YXZ Euler-angle camera view matrix
// Turns a camera pose into the rotation basis and translation terms.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-------------------------------------
//   request  | start / busy          | pos_x/y/z, pitch/yaw/roll_angle
//   result   | done (one-cycle pulse)| right_*, up_*, fwd_*, shift_u/v/w
//
// One request can be taken every cycle while busy is low. The done strobe of a
// request is delayed from the edge that takes it by the intake and queue registers,
// the 24-stage CORDIC lanes and the product and dot-product stages.
// Reset is synchronous and clears all valid flags.
// The receiver cannot stall; busy rises only if the internal queue fills.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [31:0]  pos_z,
  input  logic signed [15:0]  pitch_angle,
  input  logic signed [15:0]  yaw_angle,
  input  logic signed [15:0]  roll_angle,
  output logic                done,
  output logic signed [17:0]  right_x,
  output logic signed [17:0]  right_y,
  output logic signed [17:0]  right_z,
  output logic signed [17:0]  up_x,
  output logic signed [17:0]  up_y,
  output logic signed [17:0]  up_z,
  output logic signed [17:0]  fwd_x,
  output logic signed [17:0]  fwd_y,
  output logic signed [17:0]  fwd_z,
  output logic signed [31:0]  shift_u,
  output logic signed [31:0]  shift_v,
  output logic signed [31:0]  shift_w
);
  import evm_pkg::*;

  front_item_t f_item;
  front_item_t q_item;
  logic        push;
  logic        q_full;
  logic        q_ne;

  evm_front u_front (
    .clk(clk), .rst(rst), .start(start),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .pitch_angle(pitch_angle), .yaw_angle(yaw_angle), .roll_angle(roll_angle),
    .q_full(q_full), .busy(busy), .push(push), .item(f_item)
  );

  evm_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_item(f_item), .pop(1'b1),
    .full(q_full), .not_empty(q_ne), .rd_item(q_item)
  );

  evm_back u_back (
    .clk(clk), .rst(rst), .in_valid(q_ne), .in_item(q_item), .done(done),
    .right_x(right_x), .right_y(right_y), .right_z(right_z),
    .up_x(up_x), .up_y(up_y), .up_z(up_z),
    .fwd_x(fwd_x), .fwd_y(fwd_y), .fwd_z(fwd_z),
    .shift_u(shift_u), .shift_v(shift_v), .shift_w(shift_w)
  );

  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");
  a_right_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (right_x <= 18'sd65536 && right_x >= -18'sd65536))
    else $error("basis entry beyond unity");
  a_queue_drains: assert property (@(posedge clk) disable iff (rst) !q_full)
    else $error("request queue filled although the pipeline never stalls");
endmodule
